// ----- design/acl_pkg.sv -----
// ----------------------------------------------------------------------------
// acl_pkg: shared types and constants for the IPv4 prefix ACL
// Request codes, status codes, rule/token/result records and the prefix mask.
// ----------------------------------------------------------------------------
`default_nettype none

package acl_pkg;

    localparam int MAX_RULES_DEF = 16;
    localparam int ADDR_W        = 32;
    localparam int PLEN_W        = 6;
    localparam int IDX_W         = 4;
    localparam int STATUS_W      = 2;

    localparam logic [PLEN_W-1:0] PLEN_MAX = PLEN_W'(ADDR_W);

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_CHECK  = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_BAD_PREFIX = 2'd1,
        STAT_FULL       = 2'd2
    } status_t;

    typedef struct packed {
        logic [ADDR_W-1:0] net;
        logic [PLEN_W-1:0] plen;
        logic              deny;
    } rule_t;

    // lookup request travelling down the cell chain
    typedef struct packed {
        logic              active;
        logic [ADDR_W-1:0] addr;
        logic              hit;
        logic              deny;
        logic [IDX_W-1:0]  idx;
    } tok_t;

    typedef struct packed {
        status_t          status;
        logic             verdict;
        logic             matched;
        logic [IDX_W-1:0] idx;
        logic             host;
    } res_t;

    // top plen bits set; plen is at most ADDR_W where it matters
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
        prefix_mask = ~({ADDR_W{1'b1}} >> plen);
    endfunction

endpackage

`default_nettype wire

// ----- design/ipv4_prefix_acl_first_match.sv -----
// ----------------------------------------------------------------------------
// ipv4_prefix_acl_first_match: ordered IPv4 prefix ACL, first-match lookup
// Append, check and clear requests against a table of MAX_RULES rules kept
// in a chain of rule cells.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | kind, address, prefix_len, action
//  m_      | out | m_valid / m_ready  | status, verdict, matched, match_index,
//          |     |                    | host_bits_set
//
// Append, clear and unused kinds, and a check on an empty table, answer at
// once through the output register; a check with a non-empty table walks the
// whole cell chain, and the next request is taken once its result is out.
// One request is in flight at a time; s_ready drops while a check walks the
// chain or a finished result waits behind a full output register.
// Synchronous active-low reset empties the table; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_prefix_acl_first_match #(
    parameter int MAX_RULES = acl_pkg::MAX_RULES_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire [1:0]                    s_kind,
    input  wire [acl_pkg::ADDR_W-1:0]    s_address,
    input  wire [acl_pkg::PLEN_W-1:0]    s_prefix_len,
    input  wire                          s_action,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [acl_pkg::STATUS_W-1:0] m_status,
    output logic                         m_verdict,
    output logic                         m_matched,
    output logic [acl_pkg::IDX_W-1:0]    m_match_index,
    output logic                         m_host_bits_set
);

    localparam int CNT_W = $clog2(MAX_RULES + 1);
    localparam int SEL_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_WAIT = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic            m_valid_reg, m_valid_next;
    acl_pkg::res_t   out_reg, out_next;
    acl_pkg::res_t   hold_reg, hold_next;

    acl_pkg::tok_t   chain [MAX_RULES+1];
    acl_pkg::tok_t   tok_head;
    acl_pkg::tok_t   tok_last;
    acl_pkg::rule_t  wr_rule;
    acl_pkg::res_t   res_imm;
    acl_pkg::res_t   res_scan;
    logic [acl_pkg::ADDR_W-1:0] mask_in;

    logic accept;
    logic out_free;
    logic is_check;
    logic wr_en;
    logic plen_ok;
    logic not_full;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign plen_ok  = s_prefix_len <= acl_pkg::PLEN_MAX;
    assign not_full = cnt_reg < CNT_W'(MAX_RULES);
    assign mask_in  = acl_pkg::prefix_mask(s_prefix_len);

    assign wr_rule.net  = s_address;
    assign wr_rule.plen = s_prefix_len;
    assign wr_rule.deny = s_action;

    // immediate answer and table update for everything but a chain walk
    always_comb begin
        res_imm  = '0;
        res_imm.status = acl_pkg::STAT_OK;
        is_check = 1'b0;
        wr_en    = 1'b0;
        cnt_next = cnt_reg;
        unique case (acl_pkg::kind_t'(s_kind))
            acl_pkg::KIND_APPEND: begin
                if (!plen_ok) begin
                    res_imm.status = acl_pkg::STAT_BAD_PREFIX;
                end else if (!not_full) begin
                    res_imm.status = acl_pkg::STAT_FULL;
                end else begin
                    res_imm.host = (s_address & mask_in) != s_address;
                    wr_en        = accept;
                    if (accept) begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            acl_pkg::KIND_CHECK: begin
                is_check = cnt_reg != '0;
            end
            acl_pkg::KIND_CLEAR: begin
                if (accept) begin
                    cnt_next = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        tok_head        = '0;
        tok_head.active = accept && is_check;
        tok_head.addr   = s_address;
    end

    assign chain[0] = tok_head;

    for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
        acl_cell #(
            .IDX   (i),
            .CNT_W (CNT_W),
            .SEL_W (SEL_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .rule_cnt (cnt_reg),
            .wr_en    (wr_en),
            .wr_sel   (cnt_reg[SEL_W-1:0]),
            .wr_rule  (wr_rule),
            .tok_in   (chain[i]),
            .tok_out  (chain[i+1])
        );
    end

    assign tok_last = chain[MAX_RULES];

    always_comb begin
        res_scan         = '0;
        res_scan.status  = acl_pkg::STAT_OK;
        res_scan.matched = tok_last.hit;
        res_scan.verdict = tok_last.hit && tok_last.deny;
        res_scan.idx     = tok_last.hit ? tok_last.idx : '0;
    end

    always_comb begin
        state_next   = state_reg;
        out_next     = out_reg;
        hold_next    = hold_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (is_check) begin
                        state_next = S_SCAN;
                    end else if (out_free) begin
                        out_next     = res_imm;
                        m_valid_next = 1'b1;
                    end else begin
                        hold_next  = res_imm;
                        state_next = S_WAIT;
                    end
                end
            end
            S_SCAN: begin
                if (tok_last.active) begin
                    if (out_free) begin
                        out_next     = res_scan;
                        m_valid_next = 1'b1;
                        state_next   = S_IDLE;
                    end else begin
                        hold_next  = res_scan;
                        state_next = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    out_next     = hold_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        hold_reg <= hold_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = out_reg.status;
    assign m_verdict       = out_reg.verdict;
    assign m_matched       = out_reg.matched;
    assign m_match_index   = out_reg.idx;
    assign m_host_bits_set = out_reg.host;

endmodule

`default_nettype wire

// ----- design/acl_cell.sv -----
// ----------------------------------------------------------------------------
// acl_cell: one rule slot of the ACL chain
// Holds one rule and compares a passing lookup against it, then forwards the
// lookup to the next slot through its token register.
// ----------------------------------------------------------------------------
`default_nettype none

module acl_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5,
    parameter int SEL_W = 4
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire [CNT_W-1:0]     rule_cnt,
    input  wire                 wr_en,
    input  wire [SEL_W-1:0]     wr_sel,
    input  acl_pkg::rule_t      wr_rule,
    input  acl_pkg::tok_t       tok_in,
    output acl_pkg::tok_t       tok_out
);

    acl_pkg::rule_t rule_reg;
    acl_pkg::tok_t  tok_reg;
    acl_pkg::tok_t  tok_next;

    logic [acl_pkg::ADDR_W-1:0] mask;
    logic                       in_use;
    logic                       hit_here;

    always_ff @(posedge aclk) begin
        if (wr_en && (wr_sel == SEL_W'(IDX))) begin
            rule_reg <= wr_rule;
        end
    end

    always_comb begin
        mask     = acl_pkg::prefix_mask(rule_reg.plen);
        // slots at or above the fill count hold stale rules
        in_use   = CNT_W'(IDX) < rule_cnt;
        hit_here = tok_in.active && !tok_in.hit && in_use &&
                   ((tok_in.addr & mask) == (rule_reg.net & mask));
        tok_next = tok_in;
        if (hit_here) begin
            tok_next.hit  = 1'b1;
            tok_next.deny = rule_reg.deny;
            tok_next.idx  = acl_pkg::IDX_W'(IDX);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.active <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for ipv4_prefix_acl_first_match
// A directed table (reset state, length and table-full rejects, host bits,
// catch-all rules, first-match order) is followed by random append, check
// and clear traffic. Each result is checked against the in-bench rule table or
// a typed answer. Both channels idle at random, with one long output hold-off.
// ----------------------------------------------------------------------------

module tb;

    localparam int MAX_RULES       = acl_pkg::MAX_RULES_DEF;
    localparam int RANDOM_ITEMS    = 750;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 4 * MAX_RULES;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam acl_pkg::res_t RES_ZERO = '{status: acl_pkg::STAT_OK, verdict: 1'b0,
                                           matched: 1'b0, idx: '0, host: 1'b0};
    localparam acl_pkg::res_t RES_BAD  = '{status: acl_pkg::STAT_BAD_PREFIX,
                                           verdict: 1'b0, matched: 1'b0, idx: '0,
                                           host: 1'b0};
    localparam acl_pkg::res_t RES_FULL = '{status: acl_pkg::STAT_FULL, verdict: 1'b0,
                                           matched: 1'b0, idx: '0, host: 1'b0};

    typedef struct {
        logic [1:0]    kind;
        logic [31:0]   addr;
        logic [5:0]    plen;
        logic          act;
        int            reps;
        logic [31:0]   addr_step;
        bit            typed;
        acl_pkg::res_t res;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_kind;
    logic [31:0] s_address;
    logic [5:0]  s_prefix_len;
    logic        s_action;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic        m_verdict;
    logic        m_matched;
    logic [3:0]  m_match_index;
    logic        m_host_bits_set;

    // in-bench copy of the rule table
    logic [31:0] tbl_net  [MAX_RULES];
    logic [5:0]  tbl_len  [MAX_RULES];
    logic        tbl_deny [MAX_RULES];
    int          tbl_count = 0;

    acl_pkg::res_t verdict_q [$];

    int  errors      = 0;
    int  burst_left  = 0;
    int  idle_cycles = 0;
    bit  hold_off_go = 1'b0;
    int  n_requests = 0, n_appends = 0, n_bad_len = 0, n_full = 0, n_host = 0;
    int  n_checks = 0, n_hits = 0, n_denies = 0, n_clears = 0;

    stim_row_t dir_rows [$] = '{
        // empty table after reset, unused kind, rejected lengths
        '{acl_pkg::KIND_CHECK,  32'hFFFF_FFFF, 6'd0,  1'b0, 1, 32'd0, 1'b1, RES_ZERO},
        '{KIND_UNUSED,          32'hFFFF_FFFF, 6'd63, 1'b1, 1, 32'd0, 1'b1, RES_ZERO},
        '{acl_pkg::KIND_APPEND, 32'hFFFF_FFFF, 6'd63, 1'b1, 1, 32'd0, 1'b1, RES_BAD},
        '{acl_pkg::KIND_APPEND, 32'h0000_0000, 6'd33, 1'b0, 1, 32'd0, 1'b1, RES_BAD},
        '{acl_pkg::KIND_APPEND, 32'h0A00_0000, 6'd8,  1'b1, 1, 32'd0, 1'b0, RES_ZERO},
        '{acl_pkg::KIND_APPEND, 32'h0A01_0203, 6'd16, 1'b0, 1, 32'd0, 1'b0, RES_ZERO},
        '{acl_pkg::KIND_APPEND, 32'hC0A8_0101, 6'd32, 1'b1, 1, 32'd0, 1'b0, RES_ZERO},
        '{acl_pkg::KIND_APPEND, 32'h0000_0000, 6'd32, 1'b0, 1, 32'd0, 1'b0, RES_ZERO},
        '{acl_pkg::KIND_CHECK,  32'h0A01_0203, 6'd0,  1'b0, 1, 32'd0, 1'b0, RES_ZERO},
        '{acl_pkg::KIND_CHECK,  32'hC0A8_0101, 6'd0,  1'b0, 1, 32'd0, 1'b0, RES_ZERO},
        '{acl_pkg::KIND_CHECK,  32'h0000_0000, 6'd0,  1'b0, 1, 32'd0, 1'b0, RES_ZERO},
        // catch-all with host bits set
        '{acl_pkg::KIND_APPEND, 32'hFFFF_FFFF, 6'd0,  1'b1, 1, 32'd0, 1'b0, RES_ZERO},
        '{acl_pkg::KIND_CHECK,  32'h0B00_0000, 6'd0,  1'b0, 1, 32'd0, 1'b0, RES_ZERO},
        '{acl_pkg::KIND_CLEAR,  32'hFFFF_FFFF, 6'd63, 1'b1, 1, 32'd0, 1'b1, RES_ZERO},
        '{acl_pkg::KIND_CHECK,  32'h0A00_0001, 6'd0,  1'b0, 1, 32'd0, 1'b1, RES_ZERO},
        // fill the table, hit the last slot, then overflow
        '{acl_pkg::KIND_APPEND, 32'h0100_0000, 6'd8,  1'b1, MAX_RULES, 32'h0100_0000,
          1'b0, RES_ZERO},
        '{acl_pkg::KIND_CHECK,  32'h10AB_CDEF, 6'd0,  1'b0, 1, 32'd0, 1'b0, RES_ZERO},
        '{acl_pkg::KIND_APPEND, 32'h0000_0000, 6'd32, 1'b0, 1, 32'd0, 1'b1, RES_FULL},
        // bad length is reported ahead of a full table
        '{acl_pkg::KIND_APPEND, 32'hFFFF_FFFF, 6'd33, 1'b1, 1, 32'd0, 1'b1, RES_BAD},
        '{acl_pkg::KIND_CHECK,  32'h1100_0000, 6'd0,  1'b0, 1, 32'd0, 1'b0, RES_ZERO},
        '{acl_pkg::KIND_CLEAR,  32'h0000_0000, 6'd0,  1'b0, 1, 32'd0, 1'b1, RES_ZERO}
    };

    ipv4_prefix_acl_first_match u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_address       (s_address),
        .s_prefix_len    (s_prefix_len),
        .s_action        (s_action),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_verdict       (m_verdict),
        .m_matched       (m_matched),
        .m_match_index   (m_match_index),
        .m_host_bits_set (m_host_bits_set)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [31:0] net_mask(input logic [5:0] len);
        net_mask = (len == 6'd0) ? 32'd0 : (32'hFFFF_FFFF << (32 - int'(len)));
    endfunction

    // applies one request to the rule table and returns the answer it gives
    function automatic acl_pkg::res_t acl_apply(input logic [1:0] kind,
                                                input logic [31:0] addr,
                                                input logic [5:0] plen,
                                                input logic act);
        acl_pkg::res_t r;
        logic [31:0]   m;
        int            i;
        r = RES_ZERO;
        case (kind)
            acl_pkg::KIND_APPEND: begin
                if (plen > 6'd32) begin
                    r.status = acl_pkg::STAT_BAD_PREFIX;
                end else if (tbl_count >= MAX_RULES) begin
                    r.status = acl_pkg::STAT_FULL;
                end else begin
                    m = net_mask(plen);
                    r.host = ((addr & ~m) != 32'd0);
                    tbl_net[tbl_count]  = addr;
                    tbl_len[tbl_count]  = plen;
                    tbl_deny[tbl_count] = act;
                    tbl_count++;
                end
            end
            acl_pkg::KIND_CHECK: begin
                for (i = 0; i < tbl_count; i++) begin
                    m = net_mask(tbl_len[i]);
                    if (!r.matched && ((addr & m) == (tbl_net[i] & m))) begin
                        r.matched = 1'b1;
                        r.verdict = tbl_deny[i];
                        r.idx     = i[3:0];
                    end
                end
            end
            acl_pkg::KIND_CLEAR: begin
                tbl_count = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // offers one request, waits for acceptance and records its answer
    task automatic send_request(input logic [1:0] kind, input logic [31:0] addr,
                                input logic [5:0] plen, input logic act,
                                input bit typed, input acl_pkg::res_t typed_res);
        int            gap;
        acl_pkg::res_t predicted;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                       : $urandom_range(1, 10);
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_address    <= addr;
        s_prefix_len <= plen;
        s_action     <= act;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = acl_apply(kind, addr, plen, act);
        verdict_q.push_back(typed ? typed_res : predicted);
        n_requests++;
        case (kind)
            acl_pkg::KIND_APPEND: begin
                n_appends++;
                if (predicted.status == acl_pkg::STAT_BAD_PREFIX) n_bad_len++;
                if (predicted.status == acl_pkg::STAT_FULL) n_full++;
                if (predicted.host) n_host++;
            end
            acl_pkg::KIND_CHECK: begin
                n_checks++;
                if (predicted.matched) n_hits++;
                if (predicted.verdict) n_denies++;
            end
            acl_pkg::KIND_CLEAR: n_clears++;
            default: ;
        endcase
    endtask

    // result checker
    always @(posedge aclk) begin
        acl_pkg::res_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                exp_res = verdict_q.pop_front();
                if (m_status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, m_status);
                    errors++;
                end
                if (m_verdict !== exp_res.verdict) begin
                    $error("verdict: expected %0d, got %0d", exp_res.verdict, m_verdict);
                    errors++;
                end
                if (m_matched !== exp_res.matched) begin
                    $error("matched: expected %0d, got %0d", exp_res.matched, m_matched);
                    errors++;
                end
                if (m_match_index !== exp_res.idx) begin
                    $error("match_index: expected %0d, got %0d", exp_res.idx,
                           m_match_index);
                    errors++;
                end
                if (m_host_bits_set !== exp_res.host) begin
                    $error("host_bits_set: expected %0d, got %0d", exp_res.host,
                           m_host_bits_set);
                    errors++;
                end
            end
        end
    end

    // receiver: runs of random ready patterns, plus one long hold-off
    initial begin
        int  run;
        int  mode;
        bit  held;
        held = 1'b0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_off_go && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            mode = $urandom_range(0, 3);
            run  = $urandom_range(4, 40);
            repeat (run) begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    // watchdog: cycles with no handshake on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $error("no handshake for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int          n;
        int          k;
        int          j;
        int          pick;
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [31:0] m;
        logic [5:0]  plen;
        logic        act;

        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_kind       <= acl_pkg::KIND_APPEND;
        s_address    <= '0;
        s_prefix_len <= '0;
        s_action     <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[r]) begin
            for (k = 0; k < dir_rows[r].reps; k++) begin
                send_request(dir_rows[r].kind, dir_rows[r].addr + k * dir_rows[r].addr_step,
                             dir_rows[r].plen, dir_rows[r].act, dir_rows[r].typed,
                             dir_rows[r].res);
            end
        end

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 100) hold_off_go = 1'b1;
            pick = $urandom_range(0, 99);
            act  = 1'($urandom_range(0, 1));
            plen = 6'($urandom_range(0, 63));
            addr = $urandom;
            if (pick < 3) begin
                kind = acl_pkg::KIND_CLEAR;
            end else if (pick < 5) begin
                kind = KIND_UNUSED;
            end else if (pick < 50) begin
                kind = acl_pkg::KIND_APPEND;
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    plen = 6'($urandom_range(33, 63));
                else if (pick < 14)
                    plen = 6'd0;
                else if (pick < 26)
                    plen = 6'd32;
                else
                    plen = 6'($urandom_range(8, 31));
                // overlap an existing rule now and then so order matters
                if (tbl_count > 0 && $urandom_range(0, 2) == 0) begin
                    j = $urandom_range(0, tbl_count - 1);
                    m = net_mask(tbl_len[j]);
                    addr = (tbl_net[j] & m) | (addr & ~m);
                end
                if ($urandom_range(0, 1) == 0 && plen <= 6'd32)
                    addr = addr & net_mask(plen);
            end else begin
                kind = acl_pkg::KIND_CHECK;
                if (tbl_count > 0 && $urandom_range(0, 3) != 0) begin
                    j = $urandom_range(0, tbl_count - 1);
                    m = net_mask(tbl_len[j]);
                    addr = (tbl_net[j] & m) | (addr & ~m);
                end
            end
            send_request(kind, addr, plen, act, 1'b0, RES_ZERO);
        end
        s_valid <= 1'b0;

        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d requests: %0d appends (%0d bad length, %0d table full, %0d host bits)",
                 n_requests, n_appends, n_bad_len, n_full, n_host);
        $display("  %0d checks (%0d first-match hits, %0d denied), %0d table clears",
                 n_checks, n_hits, n_denies, n_clears);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
design/acl_pkg.sv
design/acl_cell.sv
design/ipv4_prefix_acl_first_match.sv
tb/tb.sv
